### hw/rtl/point_segment_check_top_defines.svh
// Assertion macros shared by the point segment check RTL.
`ifndef POINT_SEGMENT_CHECK_TOP_DEFINES_SVH
`define POINT_SEGMENT_CHECK_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PSC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("psc: assertion failed");
`define PSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("psc: assertion failed");
`else
`define PSC_ASSERT_IMPL(lbl, ante, cons)
`define PSC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hw/rtl/psc_pkg.sv
// Types, codes and helper functions of the point segment check.
package psc_pkg;

    localparam logic [1:0] CMD_XFORM  = 2'd0;
    localparam logic [1:0] CMD_ORIGIN = 2'd1;
    localparam logic [1:0] CMD_CELL   = 2'd2;
    localparam logic [1:0] CMD_QUERY  = 2'd3;

    localparam logic REG_DET_COUNT = 1'b0;
    localparam logic REG_STEP_INV  = 1'b1;

    localparam logic [5:0] CELL_EMPTY = 6'd63;
    localparam logic signed [15:0] Z_LIMIT = 16'sd5760;
    localparam int N_ROT = 9;
    localparam int N_AXES = 3;
    localparam int TYPE_COUNT = 3;
    localparam int OUTQ_DEPTH = 16;
    localparam int CREDIT_W = $clog2(OUTQ_DEPTH + 1);

    typedef struct packed {
        logic [1:0]          cmd;
        logic [7:0]          det;
        logic [5:0]          seg;
        logic signed [15:0]  px;
        logic signed [15:0]  py;
        logic signed [15:0]  pz;
        logic [3:0]          widx;
        logic signed [16:0]  wval;
        logic [1:0]          ctype;
        logic [5:0]          cx;
        logic [5:0]          cy;
        logic [5:0]          cz;
    } t_item;

    // Residue modulo 3 of an 8-bit number: 4 is 1 modulo 3, so base-4 digits add up.
    function automatic logic [1:0] mod3(input logic [7:0] v);
        logic [3:0] s1;
        logic [2:0] s2;
        logic [2:0] s3;
        s1 = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
        s2 = 3'(s1[1:0]) + 3'(s1[3:2]);
        if (s2 >= 3'd6) begin
            s3 = s2 - 3'd6;
        end else if (s2 >= 3'd3) begin
            s3 = s2 - 3'd3;
        end else begin
            s3 = s2;
        end
        return s3[1:0];
    endfunction

endpackage

### hw/rtl/psc_xform.sv
// Transform memories and the rotate-translate pipeline.
module psc_xform #(
    parameter int MAX_DETECTORS = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  psc_pkg::t_item  i_item,
    input  logic            i_xf_ok,
    output logic            o_valid,
    output psc_pkg::t_item  o_item
);
    import psc_pkg::*;

    localparam int DET_AW = $clog2(MAX_DETECTORS);

    logic [DET_AW-1:0]   w_addr;
    logic                w_det_ok;
    logic signed [15:0]  w_rot_val;
    logic signed [15:0]  r_rot_rd [N_ROT];
    logic signed [16:0]  r_trn_rd [N_AXES];

    logic                r_v1, r_v2, r_v3;
    logic                r_ok1, r_ok2, r_ok3;
    t_item               r_it1, r_it2, r_it3;
    logic signed [17:0]  r_q [N_AXES];
    logic signed [15:0]  r_rot2 [N_ROT];
    logic signed [33:0]  r_prod [N_ROT];
    logic signed [17:0]  n_q [N_AXES];
    logic signed [15:0]  w_p1 [N_AXES];
    logic signed [15:0]  w_d [N_AXES];

    assign w_addr   = DET_AW'(i_item.det);
    assign w_det_ok = int'(i_item.det) < MAX_DETECTORS;

    always_comb begin
        if (i_item.wval > 17'sd32767) begin
            w_rot_val = 16'sh7fff;
        end else if (i_item.wval < -17'sd32768) begin
            w_rot_val = -16'sd32768;
        end else begin
            w_rot_val = 16'(i_item.wval);
        end
    end

    for (genvar j = 0; j < N_ROT; j++) begin : g_rot
        logic signed [15:0] r_mem [MAX_DETECTORS];
        always_ff @(posedge i_clk) begin
            if (i_valid && i_item.cmd == CMD_XFORM && w_det_ok && i_item.widx == 4'(j)) begin
                r_mem[w_addr] <= w_rot_val;
            end
            r_rot_rd[j] <= r_mem[w_addr];
        end
    end

    for (genvar j = 0; j < N_AXES; j++) begin : g_trn
        logic signed [16:0] r_mem [MAX_DETECTORS];
        always_ff @(posedge i_clk) begin
            if (i_valid && i_item.cmd == CMD_XFORM && w_det_ok
                && i_item.widx == 4'(N_ROT + j)) begin
                r_mem[w_addr] <= i_item.wval;
            end
            r_trn_rd[j] <= r_mem[w_addr];
        end
    end

    assign w_p1[0] = r_it1.px;
    assign w_p1[1] = r_it1.py;
    assign w_p1[2] = r_it1.pz;

    always_comb begin
        for (int j = 0; j < N_AXES; j++) begin
            n_q[j] = 18'(w_p1[j]) - 18'(r_trn_rd[j]);
        end
    end

    // Row sums are rounded, floored by an arithmetic shift and saturated.
    always_comb begin
        logic signed [35:0] s;
        logic signed [21:0] f;
        for (int i = 0; i < N_AXES; i++) begin
            s = 36'(r_prod[i*3]) + 36'(r_prod[i*3+1]) + 36'(r_prod[i*3+2]) + 36'sd8192;
            f = s[35:14];
            if (f > 22'sd32767) begin
                w_d[i] = 16'sh7fff;
            end else if (f < -22'sd32768) begin
                w_d[i] = -16'sd32768;
            end else begin
                w_d[i] = 16'(f);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_it1  <= i_item;
        r_ok1  <= i_xf_ok;
        r_it2  <= r_it1;
        r_ok2  <= r_ok1;
        r_q    <= n_q;
        r_rot2 <= r_rot_rd;
        for (int k = 0; k < N_ROT; k++) begin
            r_prod[k] <= 34'(r_rot2[k]) * 34'(r_q[k % N_AXES]);
        end
        r_it3 <= r_it2;
        r_ok3 <= r_ok2;
    end

    always_comb begin
        o_item = r_it3;
        if (r_ok3) begin
            o_item.px = w_d[0];
            o_item.py = w_d[1];
            o_item.pz = w_d[2];
        end
    end
    assign o_valid = r_v3;

endmodule

### hw/rtl/psc_grid.sv
// Grid origin, quantizer and the cell segment memory with its clearing pass.
`include "point_segment_check_top_defines.svh"
module psc_grid #(
    parameter int GRID_STEPS = 64,
    parameter int SEGMENTS   = 36
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  psc_pkg::t_item  i_item,
    input  logic [15:0]     i_step_inv,
    output logic            o_res_valid,
    output logic            o_res_bit,
    output logic            o_busy
);
    import psc_pkg::*;

    localparam int GW = $clog2(GRID_STEPS);
    localparam int GA = 2 + 3 * GW;
    localparam int GRID_DEPTH = 3 << (3 * GW);
    localparam logic [GA-1:0] LAST_ADDR = GA'(GRID_DEPTH - 1);

    logic [5:0]          r_grid [GRID_DEPTH];
    logic signed [16:0]  r_org [N_AXES][TYPE_COUNT];
    logic                r_clr_busy;
    logic [GA-1:0]       r_clr_addr;

    logic [1:0]          w_type;
    logic signed [15:0]  w_d [N_AXES];
    logic signed [17:0]  n_off [N_AXES];
    logic                w_zrej, w_cwe;
    logic [5:0]          w_code;

    logic                r_g1_v, r_g1_q, r_g1_rej, r_g1_cwe;
    logic signed [17:0]  r_g1_off [N_AXES];
    logic [1:0]          r_g1_type;
    logic [5:0]          r_g1_seg, r_g1_code;
    logic [GA-1:0]       r_g1_caddr;

    logic                r_g2_q, r_g2_rej, r_g2_cwe;
    logic signed [34:0]  r_g2_prod [N_AXES];
    logic [1:0]          r_g2_type;
    logic [5:0]          r_g2_seg, r_g2_code;
    logic [GA-1:0]       r_g2_caddr;

    logic                r_g3_q, r_g3_rej;
    logic [5:0]          r_g3_seg, r_rd;
    logic                r_res_v, r_res_bit;

    logic [GW-1:0]       w_k [N_AXES];
    logic                w_krej;
    logic [GA-1:0]       w_raddr, w_waddr;
    logic [5:0]          w_wdata;
    logic                w_we;

    assign w_type = mod3(i_item.det);
    assign w_d[0] = i_item.px;
    assign w_d[1] = i_item.py;
    assign w_d[2] = i_item.pz;
    assign w_zrej = i_item.pz < 16'sd0 || i_item.pz > Z_LIMIT;

    always_comb begin
        for (int i = 0; i < N_AXES; i++) begin
            n_off[i] = 18'(w_d[i]) - 18'(r_org[i][w_type]);
        end
    end

    assign w_cwe = i_item.cmd == CMD_CELL && i_item.ctype != 2'd3
                   && int'(i_item.cx) < GRID_STEPS && int'(i_item.cy) < GRID_STEPS
                   && int'(i_item.cz) < GRID_STEPS;
    assign w_code = (i_item.wval < 17'sd0 || i_item.wval >= 17'(SEGMENTS))
                    ? CELL_EMPTY : 6'(i_item.wval);

    always_ff @(posedge i_clk) begin
        if (i_valid && i_item.cmd == CMD_ORIGIN && i_item.ctype != 2'd3
            && i_item.widx < 4'd3) begin
            r_org[i_item.widx[1:0]][i_item.ctype] <= i_item.wval;
        end
    end

    // Rounded index, truncated toward zero; a small negative value lands on zero.
    always_comb begin
        logic signed [35:0] v;
        w_krej = 1'b0;
        for (int i = 0; i < N_AXES; i++) begin
            v = 36'(r_g2_prod[i]) + 36'sd32768;
            w_k[i] = '0;
            if (v[35]) begin
                if (!(v[35:16] == '1 && v[15:0] != 16'd0)) begin
                    w_krej = 1'b1;
                end
            end else if (v[35:16] > 20'(GRID_STEPS - 1)) begin
                w_krej = 1'b1;
            end else begin
                w_k[i] = GW'(v[35:16]);
            end
        end
    end

    assign w_raddr = {r_g2_type, w_k[0], w_k[1], w_k[2]};
    assign w_we    = r_clr_busy || r_g2_cwe;
    assign w_waddr = r_clr_busy ? r_clr_addr : r_g2_caddr;
    assign w_wdata = r_clr_busy ? CELL_EMPTY : r_g2_code;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_grid[w_waddr] <= w_wdata;
        end
        r_rd <= r_grid[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_g1_v     <= 1'b0;
            r_g1_q     <= 1'b0;
            r_g1_cwe   <= 1'b0;
            r_g2_q     <= 1'b0;
            r_g2_cwe   <= 1'b0;
            r_g3_q     <= 1'b0;
            r_res_v    <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_ADDR) begin
                    r_clr_busy <= 1'b0;
                end
            end
            r_g1_v   <= i_valid;
            r_g1_q   <= i_valid && i_item.cmd == CMD_QUERY;
            r_g1_cwe <= i_valid && w_cwe;
            r_g2_q   <= r_g1_q;
            r_g2_cwe <= r_g1_cwe;
            r_g3_q   <= r_g2_q;
            r_res_v  <= r_g3_q;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g1_rej   <= w_zrej;
        r_g1_off   <= n_off;
        r_g1_type  <= w_type;
        r_g1_seg   <= i_item.seg;
        r_g1_code  <= w_code;
        r_g1_caddr <= {i_item.ctype, GW'(i_item.cx), GW'(i_item.cy), GW'(i_item.cz)};
        for (int i = 0; i < N_AXES; i++) begin
            r_g2_prod[i] <= 35'(r_g1_off[i]) * 35'($signed({1'b0, i_step_inv}));
        end
        r_g2_rej   <= r_g1_rej;
        r_g2_type  <= r_g1_type;
        r_g2_seg   <= r_g1_seg;
        r_g2_code  <= r_g1_code;
        r_g2_caddr <= r_g1_caddr;
        r_g3_rej   <= r_g2_rej || w_krej;
        r_g3_seg   <= r_g2_seg;
        r_res_bit  <= !r_g3_rej && r_rd != CELL_EMPTY && r_rd == r_g3_seg;
    end

    assign o_res_valid = r_res_v;
    assign o_res_bit   = r_res_bit;
    assign o_busy      = r_clr_busy;

    `PSC_ASSERT_IMPL(a_no_item_in_clear, r_clr_busy, !r_g1_v)
    `PSC_ASSERT_NEXT(a_clear_ends, r_clr_busy && r_clr_addr == LAST_ADDR, !r_clr_busy)

endmodule

### hw/rtl/psc_outq.sv
// Result queue that parts the pipeline from the output handshake.
`include "point_segment_check_top_defines.svh"
module psc_outq (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  logic i_data,
    input  logic i_pop,
    output logic o_valid,
    output logic o_data
);
    import psc_pkg::*;

    localparam int QA = $clog2(OUTQ_DEPTH);

    logic                r_mem [OUTQ_DEPTH];
    logic [QA-1:0]       r_wp, r_rp;
    logic [CREDIT_W-1:0] r_cnt;
    logic                w_pop;

    assign w_pop = i_pop && r_cnt != '0;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && w_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];

    `PSC_ASSERT_IMPL(a_no_overflow, i_push, r_cnt != CREDIT_W'(OUTQ_DEPTH))
    `PSC_ASSERT_NEXT(a_count_up, i_push && !w_pop, r_cnt == $past(r_cnt) + 1'b1)

endmodule

### hw/rtl/point_segment_check_top.sv
// Top level of the point segment check.
//
// Input channel: i_valid / o_stall carry one item per accepted cycle. Commands
// load the per-detector rotation and translation words, the per-type grid
// origin and the per-type cell segment grid; a query asks whether a lab hit lies
// in a cell of the claimed segment and gives exactly one result item. Loads give
// no result. Output channel: o_valid / i_stall carry the one-bit answer.
// The configuration port writes detector_count (index 0) and step_inverse
// (index 1). The user must write them only while the block is idle; the block itself
// does not enforce this. Throughput is one item per cycle while o_stall is low. With the
// queue empty, a query passes these stages before o_valid rises: the accepting edge loads
// the first of three transform stages (memory read, subtract, multiply; the row sum feeds
// the grid), then four grid stages (origin offset, step multiply, cell memory read,
// compare) and the result queue write. Results wait in a 16-entry queue; a credit counter
// stalls the input only when 16 query results are owed, so a stalled receiver never
// loses an item. After reset the cell memory, 3 * 2^(3*ceil(log2(GRID_STEPS))) cells
// (786432 at the default size), is swept to empty, one cell per cycle; o_stall stays
// high for that sweep. Configuration writes are taken at all times.
module point_segment_check_top #(
    parameter int MAX_DETECTORS = 256,
    parameter int GRID_STEPS    = 64,
    parameter int SEGMENTS      = 36
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_command,
    input  logic [7:0]          i_detector,
    input  logic [5:0]          i_segment,
    input  logic signed [15:0]  i_pos_x,
    input  logic signed [15:0]  i_pos_y,
    input  logic signed [15:0]  i_pos_z,
    input  logic [3:0]          i_word_index,
    input  logic signed [16:0]  i_word_value,
    input  logic [1:0]          i_crystal_type,
    input  logic [5:0]          i_cell_x,
    input  logic [5:0]          i_cell_y,
    input  logic [5:0]          i_cell_z,
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_in_bounds
);
    import psc_pkg::*;

    logic [8:0]          r_det_count;
    logic [15:0]         r_step_inv;
    logic [CREDIT_W-1:0] r_credit;

    t_item  w_item, w_xf_item;
    logic   w_accept, w_out_accept, w_xf_ok, w_xf_valid;
    logic   w_busy, w_res_valid, w_res_bit;

    assign w_item = '{cmd: i_command, det: i_detector, seg: i_segment,
                      px: i_pos_x, py: i_pos_y, pz: i_pos_z,
                      widx: i_word_index, wval: i_word_value, ctype: i_crystal_type,
                      cx: i_cell_x, cy: i_cell_y, cz: i_cell_z};

    // The input waits during the clearing sweep or when every queue slot is owed.
    assign o_stall      = w_busy || r_credit == CREDIT_W'(OUTQ_DEPTH);
    assign w_accept     = i_valid && !o_stall;
    assign w_out_accept = o_valid && !i_stall;

    // A detector at or beyond detector_count or MAX_DETECTORS passes its lab position through.
    assign w_xf_ok = {1'b0, i_detector} < r_det_count && int'(i_detector) < MAX_DETECTORS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_det_count <= 9'd0;
            r_step_inv  <= 16'd512;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_DET_COUNT: r_det_count <= i_cfg_data[8:0];
                REG_STEP_INV:  r_step_inv  <= i_cfg_data;
                default:       r_step_inv  <= r_step_inv;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            if ((w_accept && i_command == CMD_QUERY) && !w_out_accept) begin
                r_credit <= r_credit + 1'b1;
            end else if (!(w_accept && i_command == CMD_QUERY) && w_out_accept) begin
                r_credit <= r_credit - 1'b1;
            end
        end
    end

    psc_xform #(
        .MAX_DETECTORS(MAX_DETECTORS)
    ) u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_item  (w_item),
        .i_xf_ok (w_xf_ok),
        .o_valid (w_xf_valid),
        .o_item  (w_xf_item)
    );

    psc_grid #(
        .GRID_STEPS(GRID_STEPS),
        .SEGMENTS  (SEGMENTS)
    ) u_grid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_xf_valid),
        .i_item      (w_xf_item),
        .i_step_inv  (r_step_inv),
        .o_res_valid (w_res_valid),
        .o_res_bit   (w_res_bit),
        .o_busy      (w_busy)
    );

    psc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_data  (w_res_bit),
        .i_pop   (w_out_accept),
        .o_valid (o_valid),
        .o_data  (o_in_bounds)
    );

endmodule
